### sv/csp_pkg.sv
// Package with the shared types, character codes and helpers of the sentence parser.
`default_nettype none

package csp_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 64;

	typedef enum logic [2:0] {
		PH_WAIT    = 3'd0,
		PH_REC     = 3'd1,
		PH_REC_END = 3'd2,
		PH_HEX1    = 3'd3,
		PH_HEX2    = 3'd4,
		PH_NL      = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_WAITING = 3'd0,
		ST_GOOD    = 3'd1,
		ST_FAIL    = 3'd2,
		ST_COO     = 3'd3,
		ST_HIT     = 3'd4,
		ST_CHA     = 3'd5,
		ST_DET     = 3'd6
	} status_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_NUL     = 8'h00;

	// Tag characters are packed with the first character in the low byte.
	localparam logic [23:0] TAG_COO = 24'h4F4F43;
	localparam logic [23:0] TAG_HIT = 24'h544948;
	localparam logic [23:0] TAG_CHA = 24'h414843;
	localparam logic [23:0] TAG_DET = 24'h544544;

	localparam logic [2:0] TOKEN_MAX = 3'd5;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.val = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

endpackage

`default_nettype wire

### sv/csp_rx_if.sv
// Channel interface that carries received bytes into the parser.
`default_nettype none

interface csp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### sv/csp_result_if.sv
// Channel interface that carries parse results out of the parser.
`default_nettype none

interface csp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] value_first;
	logic [15:0] value_second;
	logic [15:0] value_third;

	modport source (output valid, output status, output value_first, output value_second,
		output value_third, input ready);
	modport sink (input valid, input status, input value_first, input value_second,
		input value_third, output ready);
endinterface

`default_nettype wire

### sv/checksummed_sentence_parser_core.sv
// Top level of the checksummed sentence parser: byte-wise sentence state machine and result register.
`default_nettype none

// The parser takes one received byte per cycle and returns exactly one result per byte, which
// appears in the output register the cycle after the transfer; the rate of one byte per cycle is
// set by the single register stage that holds the sentence state and the result. A new byte is
// taken whenever the output register is empty or its result is taken in the same cycle.
// Sentences have the form $payload*hh followed by a newline; the result of the newline carries
// the sentence type and up to three decimal fields, and any fault is reported as a failure.
module checksummed_sentence_parser_core #(
	parameter int unsigned MAX_PAYLOAD = csp_pkg::MAX_PAYLOAD_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	csp_rx_if.sink         rx,
	csp_result_if.source   result
);

	localparam int unsigned CountW = $clog2(MAX_PAYLOAD + 1);

	csp_pkg::phase_t  phase_q, phase_d;
	logic [7:0]       xor_q, xor_d;
	logic [7:0]       rsum_q, rsum_d;
	logic [CountW-1:0] count_q, count_d;
	logic             ovf_q, ovf_d;
	logic [2:0]       tok_q, tok_d, tok_new;
	logic             intok_q, intok_d;
	logic             dstop_q, dstop_d, dstop_new;
	logic [23:0]      tag_q, tag_d;
	logic [1:0]       taglen_q, taglen_d;
	logic [15:0]      field_q [3];
	logic [15:0]      field_d [3];

	logic             out_valid_q;
	csp_pkg::status_t status_q, status_d;
	logic [15:0]      value_first_q, value_second_q, value_third_q;
	logic [15:0]      value_first_d, value_second_d, value_third_d;

	logic [7:0]       c;
	logic             accept;
	csp_pkg::hex_t    hex;
	logic [7:0]       rsum_full;

	assign c         = rx.rx_byte;
	assign rx.ready  = !out_valid_q || result.ready;
	assign accept    = rx.valid && rx.ready;
	assign hex       = csp_pkg::hex_value(c);
	assign rsum_full = rsum_q | {4'd0, hex.val};

	always_comb begin
		phase_d = csp_pkg::PH_WAIT;
		case (phase_q)
			csp_pkg::PH_REC: begin
				if (c == csp_pkg::CH_STAR) begin
					phase_d = csp_pkg::PH_HEX1;
				end else if (c == csp_pkg::CH_NUL) begin
					phase_d = csp_pkg::PH_REC_END;
				end else begin
					phase_d = csp_pkg::PH_REC;
				end
			end
			csp_pkg::PH_REC_END: begin
				phase_d = (c == csp_pkg::CH_STAR) ? csp_pkg::PH_HEX1 : csp_pkg::PH_REC_END;
			end
			csp_pkg::PH_HEX1: begin
				phase_d = hex.ok ? csp_pkg::PH_HEX2 : csp_pkg::PH_WAIT;
			end
			csp_pkg::PH_HEX2: begin
				if (hex.ok && !ovf_q && rsum_full == xor_q) begin
					phase_d = csp_pkg::PH_NL;
				end
			end
			csp_pkg::PH_NL: begin
				phase_d = csp_pkg::PH_WAIT;
			end
			default: begin
				if (c == csp_pkg::CH_DOLLAR) begin
					phase_d = csp_pkg::PH_REC;
				end
			end
		endcase
	end

	always_comb begin
		status_d       = csp_pkg::ST_GOOD;
		value_first_d  = 16'd0;
		value_second_d = 16'd0;
		value_third_d  = 16'd0;
		case (phase_q)
			csp_pkg::PH_REC, csp_pkg::PH_REC_END: begin
				status_d = csp_pkg::ST_GOOD;
			end
			csp_pkg::PH_HEX1: begin
				if (!hex.ok) begin
					status_d = csp_pkg::ST_FAIL;
				end
			end
			csp_pkg::PH_HEX2: begin
				if (!(hex.ok && !ovf_q && rsum_full == xor_q)) begin
					status_d = csp_pkg::ST_FAIL;
				end
			end
			csp_pkg::PH_NL: begin
				status_d = csp_pkg::ST_FAIL;
				if (c == csp_pkg::CH_NEWLINE && tok_q != 3'd0 && taglen_q == 2'd3) begin
					if (tag_q == csp_pkg::TAG_COO) begin
						status_d = csp_pkg::ST_COO;
					end else if (tag_q == csp_pkg::TAG_HIT) begin
						status_d = csp_pkg::ST_HIT;
					end else if (tag_q == csp_pkg::TAG_CHA) begin
						status_d = csp_pkg::ST_CHA;
					end else if (tag_q == csp_pkg::TAG_DET) begin
						status_d = csp_pkg::ST_DET;
					end
				end
				if (status_d != csp_pkg::ST_FAIL) begin
					value_first_d  = field_q[0];
					value_second_d = field_q[1];
					value_third_d  = (status_d == csp_pkg::ST_HIT) ? field_q[2] : 16'd0;
				end
			end
			default: begin
				status_d = (c == csp_pkg::CH_DOLLAR) ? csp_pkg::ST_GOOD : csp_pkg::ST_WAITING;
			end
		endcase
	end

	always_comb begin
		xor_d     = xor_q;
		rsum_d    = rsum_q;
		count_d   = count_q;
		ovf_d     = ovf_q;
		tok_d     = tok_q;
		intok_d   = intok_q;
		dstop_d   = dstop_q;
		tag_d     = tag_q;
		taglen_d  = taglen_q;
		field_d   = field_q;
		tok_new   = tok_q;
		dstop_new = dstop_q;
		case (phase_q)
			csp_pkg::PH_REC, csp_pkg::PH_REC_END: begin
				if (c != csp_pkg::CH_STAR) begin
					if (count_q < CountW'(MAX_PAYLOAD)) begin
						count_d = count_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
					if (phase_q == csp_pkg::PH_REC && c != csp_pkg::CH_NUL) begin
						xor_d = xor_q ^ c;
						if (c == csp_pkg::CH_COMMA) begin
							intok_d = 1'b0;
						end else begin
							if (!intok_q) begin
								intok_d   = 1'b1;
								dstop_new = 1'b0;
								if (tok_q < csp_pkg::TOKEN_MAX) begin
									tok_new = tok_q + 3'd1;
								end
							end
							tok_d = tok_new;
							if (tok_new == 3'd1 && taglen_q != 2'd3) begin
								case (taglen_q)
									2'd0: tag_d[7:0]   = c;
									2'd1: tag_d[15:8]  = c;
									default: tag_d[23:16] = c;
								endcase
								taglen_d = taglen_q + 2'd1;
							end
							for (int i = 0; i < 3; i++) begin
								if (tok_new == 3'(i + 2) && !dstop_new) begin
									if (csp_pkg::is_digit(c)) begin
										field_d[i] = (field_q[i] << 3) + (field_q[i] << 1)
											+ {12'd0, 4'(c - 8'h30)};
									end else begin
										dstop_new = 1'b1;
									end
								end
							end
							dstop_d = dstop_new;
						end
					end
				end
			end
			csp_pkg::PH_HEX1: begin
				if (hex.ok) begin
					rsum_d = {hex.val, 4'd0};
				end
			end
			csp_pkg::PH_HEX2: begin
				if (hex.ok) begin
					rsum_d = rsum_full;
				end
			end
			csp_pkg::PH_NL: begin
				rsum_d = rsum_q;
			end
			default: begin
				if (c == csp_pkg::CH_DOLLAR) begin
					xor_d    = 8'd0;
					rsum_d   = 8'd0;
					count_d  = '0;
					ovf_d    = 1'b0;
					tok_d    = 3'd0;
					intok_d  = 1'b0;
					dstop_d  = 1'b0;
					tag_d    = 24'd0;
					taglen_d = 2'd0;
					for (int i = 0; i < 3; i++) begin
						field_d[i] = 16'd0;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= csp_pkg::PH_WAIT;
			xor_q    <= 8'd0;
			rsum_q   <= 8'd0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			tok_q    <= 3'd0;
			intok_q  <= 1'b0;
			dstop_q  <= 1'b0;
			tag_q    <= 24'd0;
			taglen_q <= 2'd0;
			for (int i = 0; i < 3; i++) begin
				field_q[i] <= 16'd0;
			end
		end else if (accept) begin
			phase_q  <= phase_d;
			xor_q    <= xor_d;
			rsum_q   <= rsum_d;
			count_q  <= count_d;
			ovf_q    <= ovf_d;
			tok_q    <= tok_d;
			intok_q  <= intok_d;
			dstop_q  <= dstop_d;
			tag_q    <= tag_d;
			taglen_q <= taglen_d;
			field_q  <= field_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q       <= status_d;
			value_first_q  <= value_first_d;
			value_second_q <= value_second_d;
			value_third_q  <= value_third_d;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status       = status_q;
	assign result.value_first  = value_first_q;
	assign result.value_second = value_second_q;
	assign result.value_third  = value_third_q;

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the checksummed sentence parser core with directed and random sentence traffic.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PAYLOAD_LIMIT = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_PLUS = 8'h2B;

	typedef logic [7:0] byte_q_t [$];

	typedef struct packed {
		csp_pkg::status_t status;
		logic [15:0]      v0;
		logic [15:0]      v1;
		logic [15:0]      v2;
	} parse_result_t;

	typedef enum int {
		SF_NONE,
		SF_BAD_SUM,
		SF_BAD_HEX1,
		SF_BAD_HEX2,
		SF_NO_NEWLINE,
		SF_CUT
	} sentence_fault_t;

	logic clk;
	logic arst_n;

	csp_rx_if     rx_ch ();
	csp_result_if res_ch ();

	checksummed_sentence_parser_core #(
		.MAX_PAYLOAD(PAYLOAD_LIMIT)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.result(res_ch)
	);

	csp_pkg::phase_t ph;
	logic [7:0]  xor_acc;
	logic [7:0]  sum_rx;
	logic [6:0]  pay_count;
	logic        pay_over;
	logic [2:0]  tok_num;
	logic        in_tok;
	logic        dig_stop;
	logic [23:0] tag_acc;
	logic [1:0]  tag_len;
	logic [15:0] fld [3];

	parse_result_t pending_results [$];
	int  err_count = 0;
	int  cycle_count = 0;
	int  bytes_sent = 0;
	int  hold_cycles = 0;
	bit  src_idle_on = 1'b1;
	bit  sink_idle_on = 1'b1;

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return {1'b1, 4'(c - CH_ZERO)};
		if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
		if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
		return 5'd0;
	endfunction

	function automatic void clear_sentence_state();
		xor_acc   = 8'd0;
		sum_rx    = 8'd0;
		pay_count = 7'd0;
		pay_over  = 1'b0;
		tok_num   = 3'd0;
		in_tok    = 1'b0;
		dig_stop  = 1'b0;
		tag_acc   = 24'd0;
		tag_len   = 2'd0;
		fld[0]    = 16'd0;
		fld[1]    = 16'd0;
		fld[2]    = 16'd0;
	endfunction

	function automatic parse_result_t predict_parse(input logic [7:0] c);
		parse_result_t r;
		logic [4:0] h;
		int k;
		r.status = csp_pkg::ST_GOOD;
		r.v0 = 16'd0;
		r.v1 = 16'd0;
		r.v2 = 16'd0;
		case (ph)
			csp_pkg::PH_REC, csp_pkg::PH_REC_END: begin
				if (c == csp_pkg::CH_STAR) begin
					ph = csp_pkg::PH_HEX1;
				end else begin
					if (pay_count < PAYLOAD_LIMIT) pay_count = pay_count + 7'd1;
					else pay_over = 1'b1;
					if (ph == csp_pkg::PH_REC) begin
						if (c == csp_pkg::CH_NUL) begin
							ph = csp_pkg::PH_REC_END;
						end else begin
							xor_acc = xor_acc ^ c;
							if (c == csp_pkg::CH_COMMA) begin
								in_tok = 1'b0;
							end else begin
								if (!in_tok) begin
									in_tok = 1'b1;
									dig_stop = 1'b0;
									if (tok_num < csp_pkg::TOKEN_MAX) tok_num = tok_num + 3'd1;
								end
								if (tok_num == 3'd1) begin
									if (tag_len < 2'd3) begin
										tag_acc = tag_acc | (24'(c) << (8 * tag_len));
										tag_len = tag_len + 2'd1;
									end
								end else if (tok_num >= 3'd2 && tok_num <= 3'd4) begin
									k = int'(tok_num) - 2;
									if (!dig_stop) begin
										if (c >= CH_ZERO && c <= CH_NINE)
											fld[k] = 16'(32'(fld[k]) * 10 + 32'(c - CH_ZERO));
										else
											dig_stop = 1'b1;
									end
								end
							end
						end
					end
				end
			end
			csp_pkg::PH_HEX1: begin
				h = hex_digit(c);
				if (!h[4]) begin
					ph = csp_pkg::PH_WAIT;
					r.status = csp_pkg::ST_FAIL;
				end else begin
					sum_rx = {h[3:0], 4'h0};
					ph = csp_pkg::PH_HEX2;
				end
			end
			csp_pkg::PH_HEX2: begin
				h = hex_digit(c);
				ph = csp_pkg::PH_WAIT;
				r.status = csp_pkg::ST_FAIL;
				if (h[4]) begin
					sum_rx[3:0] = h[3:0];
					if (!pay_over && sum_rx == xor_acc) begin
						ph = csp_pkg::PH_NL;
						r.status = csp_pkg::ST_GOOD;
					end
				end
			end
			csp_pkg::PH_NL: begin
				ph = csp_pkg::PH_WAIT;
				r.status = csp_pkg::ST_FAIL;
				if (c == csp_pkg::CH_NEWLINE && tok_num >= 3'd1 && tag_len == 2'd3) begin
					case (tag_acc)
						csp_pkg::TAG_COO: r.status = csp_pkg::ST_COO;
						csp_pkg::TAG_HIT: r.status = csp_pkg::ST_HIT;
						csp_pkg::TAG_CHA: r.status = csp_pkg::ST_CHA;
						csp_pkg::TAG_DET: r.status = csp_pkg::ST_DET;
						default: r.status = csp_pkg::ST_FAIL;
					endcase
					if (r.status != csp_pkg::ST_FAIL) begin
						r.v0 = fld[0];
						r.v1 = fld[1];
						r.v2 = (r.status == csp_pkg::ST_HIT) ? fld[2] : 16'd0;
					end
				end
			end
			default: begin
				ph = csp_pkg::PH_WAIT;
				if (c == csp_pkg::CH_DOLLAR) begin
					clear_sentence_state();
					ph = csp_pkg::PH_REC;
				end else begin
					r.status = csp_pkg::ST_WAITING;
				end
			end
		endcase
		return r;
	endfunction

	function automatic byte_q_t str_bytes(input string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	function automatic logic [7:0] payload_xor(input byte_q_t p);
		logic [7:0] x;
		x = 8'd0;
		foreach (p[i]) begin
			if (p[i] == csp_pkg::CH_NUL) break;
			x = x ^ p[i];
		end
		return x;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
		if (n < 4'd10) return CH_ZERO + 8'(n);
		return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] random_non_hex();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (hex_digit(c) != 5'd0);
		return c;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			res_ch.ready = 1'b0;
			hold_cycles = hold_cycles - 1;
		end else if (sink_idle_on) begin
			res_ch.ready = ($urandom_range(99) >= 27);
		end else begin
			res_ch.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rx_ch.valid && rx_ch.ready) pending_results.push_back(predict_parse(rx_ch.rx_byte));
	end

	always @(posedge clk) begin
		parse_result_t exp_r;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no expected result pending");
				err_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (res_ch.status !== exp_r.status) begin
					$error("status: expected %0d, actual %0d", exp_r.status, res_ch.status);
					err_count++;
				end
				if (res_ch.value_first !== exp_r.v0) begin
					$error("value_first: expected %0d, actual %0d", exp_r.v0, res_ch.value_first);
					err_count++;
				end
				if (res_ch.value_second !== exp_r.v1) begin
					$error("value_second: expected %0d, actual %0d", exp_r.v1, res_ch.value_second);
					err_count++;
				end
				if (res_ch.value_third !== exp_r.v2) begin
					$error("value_third: expected %0d, actual %0d", exp_r.v2, res_ch.value_third);
					err_count++;
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] c);
		@(negedge clk);
		while (src_idle_on && $urandom_range(99) < 27) begin
			rx_ch.valid = 1'b0;
			@(negedge clk);
		end
		rx_ch.valid = 1'b1;
		rx_ch.rx_byte = c;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_sentence(input byte_q_t p, input sentence_fault_t f);
		logic [7:0] sum;
		logic [7:0] hi;
		logic [7:0] lo;
		logic lower;
		sum = payload_xor(p);
		lower = 1'($urandom_range(1));
		if (f == SF_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
		send_byte(csp_pkg::CH_DOLLAR);
		foreach (p[i]) send_byte(p[i]);
		if (f == SF_CUT) return;
		send_byte(csp_pkg::CH_STAR);
		hi = (f == SF_BAD_HEX1) ? random_non_hex() : hex_char(sum[7:4], lower);
		lo = (f == SF_BAD_HEX2) ? random_non_hex() : hex_char(sum[3:0], lower);
		send_byte(hi);
		send_byte(lo);
		if (f == SF_NO_NEWLINE) begin
			do lo = 8'($urandom_range(255)); while (lo == csp_pkg::CH_NEWLINE);
			send_byte(lo);
		end else begin
			send_byte(csp_pkg::CH_NEWLINE);
		end
	endtask

	task automatic make_random_payload(output byte_q_t p);
		string tags [4] = '{"COO", "HIT", "CHA", "DET"};
		logic [7:0] c;
		int r;
		int nf;
		int nd;
		int len;
		p = {};
		if ($urandom_range(99) < 70) begin
			r = $urandom_range(9);
			if (r == 9) p.push_back(csp_pkg::CH_COMMA);
			if (r == 8) begin
				nd = $urandom_range(1, 4);
				repeat (nd) p.push_back(8'($urandom_range(8'h41, 8'h5A)));
			end else begin
				p = {p, str_bytes(tags[r % 4])};
			end
			nf = $urandom_range(4);
			repeat (nf) begin
				p.push_back(csp_pkg::CH_COMMA);
				if ($urandom_range(9) == 0) p.push_back(csp_pkg::CH_COMMA);
				nd = $urandom_range(6);
				repeat (nd) p.push_back(CH_ZERO + 8'($urandom_range(9)));
				if ($urandom_range(5) == 0) begin
					do c = 8'($urandom_range(1, 255));
					while (c == csp_pkg::CH_STAR || c == csp_pkg::CH_COMMA);
					p.push_back(c);
					repeat ($urandom_range(2)) p.push_back(CH_ZERO + 8'($urandom_range(9)));
				end
			end
			if ($urandom_range(99) < 3) begin
				len = $urandom_range(60, 70);
				while (p.size() < len) p.push_back(CH_ZERO + 8'($urandom_range(9)));
			end
		end else begin
			len = ($urandom_range(99) < 5) ? $urandom_range(60, 75) : $urandom_range(12);
			repeat (len) begin
				c = 8'($urandom_range(255));
				p.push_back(c == csp_pkg::CH_STAR ? CH_PLUS : c);
			end
		end
	endtask

	task automatic send_random_sentence();
		byte_q_t p;
		sentence_fault_t f;
		int r;
		if ($urandom_range(99) < 30) repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
		make_random_payload(p);
		r = $urandom_range(99);
		if (r < 72) f = SF_NONE;
		else if (r < 78) f = SF_BAD_SUM;
		else if (r < 83) f = SF_BAD_HEX1;
		else if (r < 88) f = SF_BAD_HEX2;
		else if (r < 94) f = SF_NO_NEWLINE;
		else f = SF_CUT;
		send_sentence(p, f);
	endtask

	task automatic test_directed();
		byte_q_t p;
		send_byte(csp_pkg::CH_NUL);
		send_byte(8'hFF);
		send_byte(8'h41);
		send_sentence(str_bytes("COO,12,34"), SF_NONE);
		send_sentence(str_bytes("HIT,65535,0,1"), SF_NONE);
		send_sentence(str_bytes("CHA,70000,123x45"), SF_NONE);
		send_sentence(str_bytes(",,DET,,5a,,7"), SF_NONE);
		send_sentence(str_bytes("HIT,1,2,3,4,5"), SF_NONE);
		send_sentence(str_bytes("COO,1"), SF_BAD_HEX1);
		send_sentence(str_bytes("DET,2"), SF_BAD_HEX2);
		send_sentence(str_bytes("COO,3"), SF_BAD_SUM);
		send_sentence(str_bytes("CHA,4"), SF_NO_NEWLINE);
		send_sentence(str_bytes("CO,1"), SF_NONE);
		send_sentence(str_bytes("XYZ,1"), SF_NONE);
		send_sentence(str_bytes(""), SF_NONE);
		p = {str_bytes("COO,1"), csp_pkg::CH_NUL, str_bytes(",9")};
		send_sentence(p, SF_NONE);
		p = str_bytes("HIT,5,7");
		while (p.size() < PAYLOAD_LIMIT) p.push_back(csp_pkg::CH_COMMA);
		send_sentence(p, SF_NONE);
		p.push_back(csp_pkg::CH_COMMA);
		send_sentence(p, SF_NONE);
	endtask

	task automatic test_random_sentences();
		while (bytes_sent < 750) send_random_sentence();
	endtask

	task automatic test_output_stall();
		hold_cycles = 300;
		repeat (4) send_random_sentence();
		send_sentence(str_bytes("DET,321,654"), SF_NONE);
	endtask

	task automatic test_full_rate();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		repeat (10) send_random_sentence();
		send_sentence(str_bytes("HIT,9,8,1"), SF_NONE);
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'd0;
		res_ch.ready = 1'b0;
		ph = csp_pkg::PH_WAIT;
		clear_sentence_state();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_sentences();
		test_output_stall();
		test_full_rate();

		@(negedge clk);
		rx_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire

### checksummed_sentence_parser_core.f
sv/csp_pkg.sv
sv/csp_rx_if.sv
sv/csp_result_if.sv
sv/checksummed_sentence_parser_core.sv
sim/tb.sv
